// ===== sv/rc4_keystream_generator_defines.svh =====
// Assertion macros for the RC4 keystream generator.
// Included by the RTL files that carry concurrent assertions; depends on nothing.
`ifndef RC4_KEYSTREAM_GENERATOR_DEFINES_SVH
`define RC4_KEYSTREAM_GENERATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every rising edge outside reset.
`define RC4KG_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
        else $error("rc4kg assertion failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define RC4KG_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
        else $error("rc4kg assertion failed");
`else
`define RC4KG_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons)
`define RC4KG_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons)
`endif
`endif

// ===== sv/rc4kg_pkg.sv =====
// Shared types and constants of the RC4 keystream generator.
// Used by the permutation memory, the key memory and the top level; no dependencies.
`default_nettype none

package rc4kg_pkg;

    localparam int KEY_STORE_DEPTH = 256;
    localparam int KEY_AW = (KEY_STORE_DEPTH > 1) ? $clog2(KEY_STORE_DEPTH) : 1;
    localparam int SBOX_SIZE = 256;
    // Longest key the schedule can use.
    localparam int LEN_MAX = (KEY_STORE_DEPTH < SBOX_SIZE) ? KEY_STORE_DEPTH : SBOX_SIZE;

    typedef enum logic [1:0] {
        REQ_LOAD_KEY = 2'd0,
        REQ_SCHEDULE = 2'd1,
        REQ_STREAM   = 2'd2,
        REQ_UNUSED   = 2'd3
    } req_t;

    // Write port of the permutation memory.
    typedef struct packed {
        logic       we;
        logic [7:0] addr;
        logic [7:0] data;
    } sbox_wr_t;

endpackage

`default_nettype wire

// ===== sv/rc4kg_sbox_ram.sv =====
// Permutation memory of the RC4 keystream generator: 256 bytes, one write and one read port.
// Depends on rc4kg_pkg for the write port struct.
`default_nettype none

module rc4kg_sbox_ram (
    input  wire logic               clk,
    input  wire rc4kg_pkg::sbox_wr_t wr,
    input  wire logic [7:0]         rd_addr,
    output logic [7:0]              rd_data
);

    logic [7:0] mem [rc4kg_pkg::SBOX_SIZE];

    // A read at the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== sv/rc4kg_key_ram.sv =====
// Key store of the RC4 keystream generator: one write and one read port, registered read.
// Depends on rc4kg_pkg for its depth.
`default_nettype none

module rc4kg_key_ram (
    input  wire logic                         clk,
    input  wire logic                         we,
    input  wire logic [rc4kg_pkg::KEY_AW-1:0] waddr,
    input  wire logic [7:0]                   wdata,
    input  wire logic [rc4kg_pkg::KEY_AW-1:0] raddr,
    output logic [7:0]                        rdata
);

    logic [7:0] mem [rc4kg_pkg::KEY_STORE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/rc4_keystream_generator.sv =====
// Top level of the RC4 keystream generator: request decoding, sequencer and output register.
// Depends on rc4kg_pkg, rc4kg_sbox_ram, rc4kg_key_ram and the assertion macro header.
`include "rc4_keystream_generator_defines.svh"
`default_nettype none

// A transaction is taken at a rising edge where start is high and busy is low.
// A key-load transaction writes the key store in that same edge and keeps busy
// low. A keystream transaction keeps busy high through states K1, K2 and K3
// after the accepting edge. The permutation lives in one synchronous memory
// with one read port and one write port. The reads of s[i], s[j] and
// s[s[i]+s[j]] depend on each other and are issued in turn in states IDLE,
// K1 and K2, the first at the accepting edge. The two swap writes go out with
// the third read and in the cycle after it. When keep is set, the byte appears
// on stream_byte with stream_strobe high for exactly one cycle, the first cycle
// with busy low again. The receiver cannot hold it off, so it must take it
// then. A schedule transaction first fills the permutation with the identity
// in state INIT, then runs the 256 key scheduling steps, each through states
// KS0 to KS3. A keystream transaction before any schedule has run produces
// nothing and keeps busy low. key_length may be written only while busy is low
// and no byte is pending; 0 acts as 1 and values above 256 act as 256.
module rc4_keystream_generator (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [1:0] req_type,
    input  wire logic [7:0] key_index,
    input  wire logic [7:0] key_byte,
    input  wire logic       keep,
    output logic            stream_strobe,
    output logic [7:0]      stream_byte,
    input  wire logic       key_length_we,
    input  wire logic [8:0] key_length
);

    // One-hot sequencer states. The KS states run one key scheduling step,
    // the K states run one keystream step.
    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_INIT = 9'b000000010,
        ST_KS0  = 9'b000000100,
        ST_KS1  = 9'b000001000,
        ST_KS2  = 9'b000010000,
        ST_KS3  = 9'b000100000,
        ST_K1   = 9'b001000000,
        ST_K2   = 9'b010000000,
        ST_K3   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [8:0] key_length_reg;
    logic [7:0] i_reg, i_next;
    logic [7:0] j_reg, j_next;
    logic [8:0] k_reg, k_next;
    logic       scheduled_reg, scheduled_next;
    logic [7:0] held_reg, held_next;
    logic [7:0] sj_reg, sj_next;
    logic [7:0] sum_reg, sum_next;
    logic       keep_reg, keep_next;
    logic       strobe_reg, strobe_next;
    logic [7:0] byte_reg, byte_next;

    logic       accept;
    logic [8:0] eff_len;
    logic [8:0] k_inc;
    logic [7:0] j_step;
    logic [7:0] out_sel;

    rc4kg_pkg::sbox_wr_t sbox_wr;
    logic [7:0]          sbox_raddr;
    logic [7:0]          sbox_rdata;
    logic                key_we;
    logic [7:0]          key_rdata;

    rc4kg_sbox_ram u_sbox (
        .clk     (clk),
        .wr      (sbox_wr),
        .rd_addr (sbox_raddr),
        .rd_data (sbox_rdata)
    );

    rc4kg_key_ram u_key (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_index[rc4kg_pkg::KEY_AW-1:0]),
        .wdata (key_byte),
        .raddr (k_reg[rc4kg_pkg::KEY_AW-1:0]),
        .rdata (key_rdata)
    );

    assign busy          = (state_reg != ST_IDLE);
    assign accept        = start && !busy;
    assign stream_strobe = strobe_reg;
    assign stream_byte   = byte_reg;

    // Key bytes beyond the store are dropped.
    assign key_we = accept && (req_type == rc4kg_pkg::REQ_LOAD_KEY)
                    && ({1'b0, key_index} < 9'(rc4kg_pkg::KEY_STORE_DEPTH));

    // Length actually used by the schedule.
    always_comb
    begin
        if (key_length_reg == 9'd0)
        begin
            eff_len = 9'd1;
        end
        else if (key_length_reg > 9'(rc4kg_pkg::LEN_MAX))
        begin
            eff_len = 9'(rc4kg_pkg::LEN_MAX);
        end
        else
        begin
            eff_len = key_length_reg;
        end
    end

    assign k_inc = k_reg + 9'd1;

    // The scheduling step adds the key byte, the keystream step does not.
    assign j_step = (state_reg == ST_KS1) ? (j_reg + sbox_rdata + key_rdata)
                                          : (j_reg + sbox_rdata);

    // The read of s[sum] was issued in the same edge that wrote s[i], so it
    // returns pre-swap contents; fix up the two swapped entries by hand.
    always_comb
    begin
        if (sum_reg == j_reg)
        begin
            out_sel = held_reg;
        end
        else if (sum_reg == i_reg)
        begin
            out_sel = sj_reg;
        end
        else
        begin
            out_sel = sbox_rdata;
        end
    end

    // Memory address and write control.
    always_comb
    begin
        sbox_wr.we   = 1'b0;
        sbox_wr.addr = i_reg;
        sbox_wr.data = sbox_rdata;
        sbox_raddr   = i_reg + 8'd1;
        case (state_reg)
            ST_IDLE:
            begin
                sbox_raddr = i_reg + 8'd1;
            end
            ST_INIT:
            begin
                sbox_wr.we   = 1'b1;
                sbox_wr.data = i_reg;
            end
            ST_KS0:
            begin
                sbox_raddr = i_reg;
            end
            ST_KS1, ST_K1:
            begin
                sbox_raddr = j_step;
            end
            ST_KS2:
            begin
                sbox_wr.we = 1'b1;
            end
            ST_K2:
            begin
                sbox_wr.we = 1'b1;
                sbox_raddr = held_reg + sbox_rdata;
            end
            ST_KS3, ST_K3:
            begin
                sbox_wr.we   = 1'b1;
                sbox_wr.addr = j_reg;
                sbox_wr.data = held_reg;
            end
            default:
            begin
                sbox_wr.we = 1'b0;
            end
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        scheduled_next = scheduled_reg;
        held_next      = held_reg;
        sj_next        = sj_reg;
        sum_next       = sum_reg;
        keep_next      = keep_reg;
        strobe_next    = 1'b0;
        byte_next      = byte_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req_type == rc4kg_pkg::REQ_SCHEDULE))
                begin
                    state_next = ST_INIT;
                    i_next     = 8'd0;
                    j_next     = 8'd0;
                    k_next     = 9'd0;
                end
                else if (accept && (req_type == rc4kg_pkg::REQ_STREAM) && scheduled_reg)
                begin
                    state_next = ST_K1;
                    i_next     = i_reg + 8'd1;
                    keep_next  = keep;
                end
            end
            ST_INIT:
            begin
                i_next = i_reg + 8'd1;
                if (i_reg == 8'hFF)
                begin
                    state_next = ST_KS0;
                end
            end
            ST_KS0:
            begin
                state_next = ST_KS1;
            end
            ST_KS1, ST_K1:
            begin
                held_next  = sbox_rdata;
                j_next     = j_step;
                state_next = (state_reg == ST_KS1) ? ST_KS2 : ST_K2;
            end
            ST_KS2:
            begin
                state_next = ST_KS3;
            end
            ST_KS3:
            begin
                i_next = i_reg + 8'd1;
                k_next = (k_inc >= eff_len) ? 9'd0 : k_inc;
                if (i_reg == 8'hFF)
                begin
                    state_next     = ST_IDLE;
                    j_next         = 8'd0;
                    scheduled_next = 1'b1;
                end
                else
                begin
                    state_next = ST_KS0;
                end
            end
            ST_K2:
            begin
                sj_next    = sbox_rdata;
                sum_next   = held_reg + sbox_rdata;
                state_next = ST_K3;
            end
            ST_K3:
            begin
                strobe_next = keep_reg;
                byte_next   = out_sel;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            i_reg          <= 8'd0;
            j_reg          <= 8'd0;
            k_reg          <= 9'd0;
            scheduled_reg  <= 1'b0;
            strobe_reg     <= 1'b0;
            keep_reg       <= 1'b0;
            key_length_reg <= 9'd16;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            scheduled_reg <= scheduled_next;
            strobe_reg    <= strobe_next;
            keep_reg      <= keep_next;
            if (key_length_we)
            begin
                key_length_reg <= key_length;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
        sj_reg   <= sj_next;
        sum_reg  <= sum_next;
        byte_reg <= byte_next;
    end

    // A byte only leaves right after the last cycle of a keystream step.
    `RC4KG_ASSERT_IMP(a_strobe_src, clk, rst_n, strobe_reg, $past(state_reg == ST_K3))
    // A keystream step never starts without a finished schedule.
    `RC4KG_ASSERT_IMP(a_step_sched, clk, rst_n, state_reg == ST_K1, scheduled_reg)
    // The key position stays inside the used key length.
    `RC4KG_ASSERT_IMP(a_key_pos, clk, rst_n, state_reg == ST_KS0, k_reg < eff_len)
    // The last scheduling step leaves both indices cleared and the block ready.
    `RC4KG_ASSERT_NXT(a_sched_end, clk, rst_n, (state_reg == ST_KS3) && (i_reg == 8'hFF),
        (state_reg == ST_IDLE) && (i_reg == 8'd0) && (j_reg == 8'd0) && scheduled_reg)

endmodule

`default_nettype wire

// ===== verif/rc4kg_stream_check.sv =====
`timescale 1ns / 1ps
// Checker for the RC4 keystream generator. It watches the request, configuration and result
// ports, keeps its own copy of the permutation and key store, and compares every emitted byte.
// Depends on rc4kg_pkg for the request codes and the store sizes.
module rc4kg_stream_check (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       busy,
    input  logic [1:0] req_type,
    input  logic [7:0] key_index,
    input  logic [7:0] key_byte,
    input  logic       keep,
    input  logic       stream_strobe,
    input  logic [7:0] stream_byte,
    input  logic       key_length_we,
    input  logic [8:0] key_length,
    output int         fail_count,
    output int         outstanding
);

    logic [7:0] perm [rc4kg_pkg::SBOX_SIZE];
    logic [7:0] key_mem [rc4kg_pkg::KEY_STORE_DEPTH];
    logic [7:0] pos_i;
    logic [7:0] pos_j;
    logic       perm_ready;
    logic [8:0] len_reg;
    logic [7:0] expected_bytes [$];
    int         errors = 0;

    // Identity fill followed by the 256 key mixing steps.
    task automatic run_key_schedule();
        int         eff;
        int         k;
        logic [7:0] j;
        logic [7:0] t;
        eff = (len_reg == 0) ? 1 : ((len_reg > rc4kg_pkg::LEN_MAX) ? rc4kg_pkg::LEN_MAX
                                                                  : int'(len_reg));
        for (int n = 0; n < rc4kg_pkg::SBOX_SIZE; n++)
        begin
            perm[n] = n[7:0];
        end
        j = 8'd0;
        k = 0;
        for (int n = 0; n < rc4kg_pkg::SBOX_SIZE; n++)
        begin
            j = j + perm[n] + key_mem[k];
            t = perm[n];
            perm[n] = perm[j];
            perm[j] = t;
            k++;
            if (k >= eff)
            begin
                k = 0;
            end
        end
        pos_i = 8'd0;
        pos_j = 8'd0;
        perm_ready = 1'b1;
    endtask

    task automatic advance_stream(output logic [7:0] b);
        logic [7:0] t;
        logic [7:0] sum;
        pos_i = pos_i + 8'd1;
        pos_j = pos_j + perm[pos_i];
        t = perm[pos_i];
        perm[pos_i] = perm[pos_j];
        perm[pos_j] = t;
        sum = perm[pos_i] + perm[pos_j];
        b = perm[sum];
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic [7:0] b;
        if (!rst_n)
        begin
            pos_i = 8'd0;
            pos_j = 8'd0;
            perm_ready = 1'b0;
            len_reg = 9'd16;
            expected_bytes.delete();
            outstanding <= 0;
            fail_count <= errors;
        end
        else
        begin
            if (key_length_we)
            begin
                len_reg = key_length;
            end
            if (stream_strobe)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("stream_byte: no byte expected, got %02h", stream_byte);
                    errors++;
                end
                else
                begin
                    b = expected_bytes.pop_front();
                    if (stream_byte !== b)
                    begin
                        $error("stream_byte mismatch: expected %02h, got %02h", b, stream_byte);
                        errors++;
                    end
                end
            end
            if (start && !busy)
            begin
                case (rc4kg_pkg::req_t'(req_type))
                    rc4kg_pkg::REQ_LOAD_KEY:
                    begin
                        if (key_index < rc4kg_pkg::KEY_STORE_DEPTH)
                        begin
                            key_mem[key_index] = key_byte;
                        end
                    end
                    rc4kg_pkg::REQ_SCHEDULE:
                    begin
                        run_key_schedule();
                    end
                    rc4kg_pkg::REQ_STREAM:
                    begin
                        if (perm_ready)
                        begin
                            advance_stream(b);
                            if (keep)
                            begin
                                expected_bytes.push_back(b);
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            fail_count <= errors;
            outstanding <= expected_bytes.size();
        end
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Top of the RC4 keystream generator testbench: clock, reset, stimulus and verdict.
// Depends on rc4kg_pkg, the rc4_keystream_generator RTL and the rc4kg_stream_check module.
module tb;

    // The limit sits well above the slowest correct run; a schedule transaction alone
    // keeps the block busy through the identity fill and all 256 key scheduling steps.
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_ITEMS = 800;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [1:0] req_type;
    logic [7:0] key_index;
    logic [7:0] key_byte;
    logic       keep;
    logic       stream_strobe;
    logic [7:0] stream_byte;
    logic       key_length_we;
    logic [8:0] key_length;

    int fail_count;
    int outstanding;
    int cycle_count = 0;
    // Percentage of cycles in which the request side holds off its next transaction.
    int idle_pct = 0;
    int random_items = 0;
    // Key length the next schedule will use; it starts at the reset value of the register.
    int cur_len = 16;
    // Key store entries that have been written, so that a schedule never reads an
    // entry whose content is still undefined.
    bit key_written [rc4kg_pkg::KEY_STORE_DEPTH];

    rc4_keystream_generator uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .key_index     (key_index),
        .key_byte      (key_byte),
        .keep          (keep),
        .stream_strobe (stream_strobe),
        .stream_byte   (stream_byte),
        .key_length_we (key_length_we),
        .key_length    (key_length)
    );

    rc4kg_stream_check stream_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .key_index     (key_index),
        .key_byte      (key_byte),
        .keep          (keep),
        .stream_strobe (stream_strobe),
        .stream_byte   (stream_byte),
        .key_length_we (key_length_we),
        .key_length    (key_length),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost byte ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Offers one transaction and returns right after the edge that accepts it. Every task
    // returns just after a rising edge, and start is written at most once per time step,
    // so back-to-back transactions keep start high without a glitch.
    task automatic issue(input rc4kg_pkg::req_t rq, input logic [7:0] idx,
                         input logic [7:0] kb, input logic kp);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req_type <= rq;
        key_index <= idx;
        key_byte <= kb;
        keep <= kp;
        // busy read right after the edge still holds its value from before that edge.
        do
        begin
            @(posedge clk);
        end
        while (busy);
        if (rq == rc4kg_pkg::REQ_LOAD_KEY)
        begin
            key_written[idx] = 1'b1;
        end
        // Ignored request codes do not count toward the random budget.
        if (rq != rc4kg_pkg::REQ_UNUSED)
        begin
            random_items++;
        end
    endtask

    task automatic load_key(input logic [7:0] idx);
        issue(rc4kg_pkg::REQ_LOAD_KEY, idx, 8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    task automatic run_schedule();
        issue(rc4kg_pkg::REQ_SCHEDULE, 8'($urandom_range(255)), 8'($urandom_range(255)),
              1'($urandom_range(1)));
    endtask

    task automatic stream_step(input logic kp);
        issue(rc4kg_pkg::REQ_STREAM, 8'($urandom_range(255)), 8'($urandom_range(255)), kp);
    endtask

    task automatic stray_unused();
        issue(rc4kg_pkg::REQ_UNUSED, 8'($urandom_range(255)), 8'($urandom_range(255)),
              1'($urandom_range(1)));
    endtask

    // Holds off new requests until every expected byte has been taken. A discarded
    // keystream step or a schedule produces no byte, so after the last byte the block
    // may still be working: a short pause covers the former, the busy wait the latter.
    task automatic drain();
        start <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (outstanding != 0);
        repeat (8) @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    // Only called right after drain(), so the block is idle with no byte pending.
    task automatic write_key_length(input int len);
        key_length_we <= 1'b1;
        key_length <= len[8:0];
        @(posedge clk);
        key_length_we <= 1'b0;
        cur_len = len;
    endtask

    // One well-formed session: optionally a new key length, key bytes for every position
    // the schedule will read, the schedule itself, then a run of keystream steps. A little
    // noise is mixed in: unused request codes, stray key loads and early reschedules.
    task automatic run_session();
        int pick;
        int steps;
        int len;
        drain();
        pick = $urandom_range(99);
        if (pick < 80)
        begin
            if (pick < 8)
            begin
                len = rc4kg_pkg::LEN_MAX;
            end
            else if (pick < 16)
            begin
                len = 1;
            end
            else if (pick < 26)
            begin
                len = $urandom_range(25, 255);
            end
            else
            begin
                len = $urandom_range(2, 24);
            end
            write_key_length(len);
        end
        // Short keys are partly reloaded each session so that their content changes;
        // long keys only fill in the positions that were never written.
        for (int k = 0; k < cur_len; k++)
        begin
            if (!key_written[k] || (cur_len <= 32 && $urandom_range(2) == 0))
            begin
                load_key(k[7:0]);
            end
            if ($urandom_range(19) == 0)
            begin
                stray_unused();
            end
        end
        run_schedule();
        steps = $urandom_range(8, 40);
        repeat (steps)
        begin
            pick = $urandom_range(99);
            if (pick < 4)
            begin
                stray_unused();
            end
            else if (pick < 9)
            begin
                load_key(8'($urandom_range(255)));
            end
            else if (pick < 11)
            begin
                run_schedule();
            end
            else
            begin
                // Mostly kept bytes, with discarded steps sprinkled in.
                stream_step($urandom_range(4) != 0);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        req_type = rc4kg_pkg::REQ_LOAD_KEY;
        key_index = 8'd0;
        key_byte = 8'd0;
        keep = 1'b0;
        key_length_we = 1'b0;
        key_length = 9'd16;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Before any schedule, keystream steps with either keep value
        // and the unused request code must all pass without a byte.
        issue(rc4kg_pkg::REQ_UNUSED, 8'hFF, 8'hFF, 1'b1);
        stream_step(1'b1);
        stream_step(1'b0);
        // Sixteen key bytes for the reset key length, with both byte extremes.
        for (int k = 0; k < 16; k++)
        begin
            if (k == 0)
            begin
                issue(rc4kg_pkg::REQ_LOAD_KEY, k[7:0], 8'h00, 1'b0);
            end
            else if (k == 1)
            begin
                issue(rc4kg_pkg::REQ_LOAD_KEY, k[7:0], 8'hFF, 1'b1);
            end
            else
            begin
                load_key(k[7:0]);
            end
        end
        // Highest key position; not read by this schedule.
        issue(rc4kg_pkg::REQ_LOAD_KEY, 8'hFF, 8'hA5, 1'b0);
        run_schedule();
        stream_step(1'b1);
        stream_step(1'b0);
        stream_step(1'b1);
        issue(rc4kg_pkg::REQ_UNUSED, 8'h00, 8'h00, 1'b0);
        stream_step(1'b1);
        // A second schedule restarts the stream from the same key.
        run_schedule();
        stream_step(1'b1);

        // Random part in three phases of request-side idling: light, heavy, none.
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            if (random_items < RANDOM_ITEMS / 3)
            begin
                idle_pct = 13;
            end
            else if (random_items < 2 * RANDOM_ITEMS / 3)
            begin
                idle_pct = 46;
            end
            else
            begin
                idle_pct = 0;
            end
            run_session();
        end

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
